>>> hdl/umds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umds_pkg
// Operation codes and the control and status bundles shared by the
// multiply / divide / shift unit and its serial core.
// ----------------------------------------------------------------------------
package umds_pkg;

   localparam int OP_BITS    = 3;
   localparam int SHAMT_BITS = 6;

   typedef enum logic [OP_BITS-1:0] {
      OP_MUL = 3'd0,
      OP_QUO = 3'd1,
      OP_REM = 3'd2,
      OP_SHL = 3'd3,
      OP_SHR = 3'd4
   } op_type;

   typedef struct packed {
      logic   start;
      logic   take;
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } stat_type;

endpackage

>>> hdl/umds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umds_core
// Bit-serial engine: shift-and-add multiply, radix-2 restoring divide and
// one-bit-per-cycle logical shifts over a shared set of shift registers.
// ----------------------------------------------------------------------------
module umds_core #(
   parameter int WORD_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  umds_pkg::ctl_type           ctl,
   input  logic [WORD_BITS-1:0]        operand_a,
   input  logic [WORD_BITS-1:0]        operand_b,
   output umds_pkg::stat_type          stat,
   output logic [WORD_BITS-1:0]        result,
   output logic                        divide_by_zero
);
   import umds_pkg::*;

   localparam int CW = $clog2(WORD_BITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 dz_ff, dz_in;

   logic [SHAMT_BITS-1:0] shamt;
   logic [WORD_BITS:0]    trial;
   logic [WORD_BITS-1:0]  diff;
   logic                  ge;

   assign shamt = operand_b[SHAMT_BITS-1:0];
   assign trial = {acc_ff, x_ff[WORD_BITS-1]};
   assign diff  = trial[WORD_BITS-1:0] - y_ff;
   assign ge    = trial >= {1'b0, y_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      dz_in    = dz_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_RUN;
               op_in    = ctl.op;
               x_in     = operand_a;
               y_in     = operand_b;
               acc_in   = '0;
               dz_in    = 1'b0;
               cnt_in   = '0;
               case (ctl.op)
                  OP_MUL: cnt_in = CW'(WORD_BITS);
                  OP_QUO, OP_REM: begin
                     if (operand_b == '0) begin
                        dz_in = 1'b1;
                        x_in  = '0;
                     end else begin
                        cnt_in = CW'(WORD_BITS);
                     end
                  end
                  OP_SHL, OP_SHR: begin
                     if (int'(shamt) < WORD_BITS) begin
                        cnt_in = CW'(shamt);
                     end else begin
                        x_in = '0;
                     end
                  end
                  default: x_in = '0;
               endcase
            end
         end
         ST_RUN: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - CW'(1);
               case (op_ff)
                  OP_MUL: begin
                     if (y_ff[0]) begin
                        acc_in = acc_ff + x_ff;
                     end
                     x_in = {x_ff[WORD_BITS-2:0], 1'b0};
                     y_in = {1'b0, y_ff[WORD_BITS-1:1]};
                  end
                  OP_QUO, OP_REM: begin
                     acc_in = ge ? diff : trial[WORD_BITS-1:0];
                     x_in   = {x_ff[WORD_BITS-2:0], ge};
                  end
                  OP_SHL: x_in = {x_ff[WORD_BITS-2:0], 1'b0};
                  OP_SHR: x_in = {1'b0, x_ff[WORD_BITS-1:1]};
                  default: x_in = x_ff;
               endcase
            end
         end
         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      dz_ff  <= dz_in;
   end

   always_comb begin
      case (op_ff)
         OP_MUL, OP_REM: result = acc_ff;
         OP_QUO, OP_SHL, OP_SHR: result = x_ff;
         default: result = '0;
      endcase
   end

   assign divide_by_zero = dz_ff;
   assign stat.busy      = (state_ff != ST_IDLE);
   assign stat.done      = (state_ff == ST_DONE);

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == ST_IDLE)
      else $error("request started while core busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> int'(cnt_ff) <= WORD_BITS)
      else $error("iteration count out of range");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      stat.done && dz_ff |-> result == '0)
      else $error("divide by zero gave nonzero result");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      stat.done && !ctl.take |=> stat.done)
      else $error("result dropped before transfer");
`endif

endmodule

>>> hdl/unsigned_muldiv_shift_unit_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_muldiv_shift_unit_64
// Unsigned multiply, divide, modulo and logical shift unit, computed one
// operand bit per cycle in a serial core, with a registered response stage.
//
//   channel  ports                                         role
//   req      req_valid req_stall req_op req_operand_a/b    request in
//   rsp      rsp_valid rsp_stall rsp_result
//            rsp_divide_by_zero                            response out
//
// Multiply and divide iterate over all WORD_BITS operand bits in the core;
// shifts iterate as many times as the shift amount, while zero divisors and
// unused codes skip the iteration.
// A new request is taken while a finished response waits in rsp.
// Reset (synchronous) empties the core and the response stage.
// ----------------------------------------------------------------------------
module unsigned_muldiv_shift_unit_64 #(
   parameter int WORD_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [umds_pkg::OP_BITS-1:0] req_op,
   input  logic [WORD_BITS-1:0]        req_operand_a,
   input  logic [WORD_BITS-1:0]        req_operand_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [WORD_BITS-1:0]        rsp_result,
   output logic                        rsp_divide_by_zero
);
   import umds_pkg::*;

   ctl_type              ctl;
   stat_type             stat;
   logic [WORD_BITS-1:0] core_result;
   logic                 core_dz;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_result_ff, rsp_result_in;
   logic                 rsp_dz_ff, rsp_dz_in;
   logic                 slot_free;

   assign req_stall = stat.busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign ctl.start = req_valid && !stat.busy;
   assign ctl.take  = slot_free;
   assign ctl.op    = op_type'(req_op);

   umds_core #(
      .WORD_BITS(WORD_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .operand_a      (req_operand_a),
      .operand_b      (req_operand_b),
      .stat           (stat),
      .result         (core_result),
      .divide_by_zero (core_dz)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_dz_in     = rsp_dz_ff;
      if (stat.done && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = core_result;
         rsp_dz_in     = core_dz;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule

>>> bench/unsigned_muldiv_shift_unit_64_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_muldiv_shift_unit_64_tb
// Self-checking bench for the 64-bit unsigned multiply / divide / shift unit.
// Directed corner requests for every operation come first: operand extremes,
// zero divisors, dividends with the top bit set, shift amounts at the word
// edge with junk in the upper amount bits, and the unused operation codes.
// A long random mix follows, first without idling and then with random
// gaps and random response stalls. Further phases cover a long response
// hold-off that backs the unit up, and a sender pause until the unit drains.
// Each request's response is predicted on acceptance, queued in order, and
// compared field by field with what the unit returns.
// ----------------------------------------------------------------------------
module unsigned_muldiv_shift_unit_64_tb;
   import umds_pkg::*;

   localparam int          WORD_BITS     = 64;
   localparam logic [2:0]  OP_UNUSED_5   = 3'd5;
   localparam logic [2:0]  OP_UNUSED_6   = 3'd6;
   localparam logic [2:0]  OP_UNUSED_7   = 3'd7;
   localparam logic [63:0] WORD_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;
   localparam int          HOLD_CYCLES   = 600;
   localparam int          QUIET_LIMIT   = 4000;
   localparam int          DRAIN_CYCLES  = 100;
   localparam int          MAX_REPORTS   = 10;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
      logic [63:0] result;
      logic        divide_by_zero;
   } response_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_BITS-1:0]   req_op = '0;
   logic [WORD_BITS-1:0] req_operand_a = '0;
   logic [WORD_BITS-1:0] req_operand_b = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WORD_BITS-1:0] rsp_result;
   logic                 rsp_divide_by_zero;

   response_type pending_responses[$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   bit           req_idle_on = 1'b0;
   bit           rsp_idle_on = 1'b0;
   bit           holdoff_go = 1'b0;
   logic [2:0]   unused_ops[3] = '{OP_UNUSED_5, OP_UNUSED_6, OP_UNUSED_7};

   unsigned_muldiv_shift_unit_64 #(.WORD_BITS(WORD_BITS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result         (rsp_result),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic response_type predict_response(input logic [2:0] op,
                                                     input logic [63:0] a,
                                                     input logic [63:0] b);
      response_type r;
      r.op = op;
      r.operand_a = a;
      r.operand_b = b;
      r.result = '0;
      r.divide_by_zero = 1'b0;
      case (op)
         OP_MUL: r.result = a * b;
         OP_QUO, OP_REM: begin
            if (b == '0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               r.result = (op == OP_QUO) ? a / b : a % b;
            end
         end
         OP_SHL: r.result = a << b[SHAMT_BITS-1:0];
         OP_SHR: r.result = a >> b[SHAMT_BITS-1:0];
         default: r.result = '0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: w = 64'($urandom_range(0, 255));
         1: w = WORD_MAX - 64'($urandom_range(0, 255));
         2: w = 64'd1 << $urandom_range(0, 63);
         3: w = (64'd1 << $urandom_range(1, 63)) - 64'd1;
         4: w = TOP_BIT | w;
         5: w = 64'($urandom);
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [63:0] a,
                               input logic [63:0] b);
      int gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      pending_responses.push_back(predict_response(op, a, b));
      gap = 0;
      if (req_idle_on && $urandom_range(0, 99) < 34)
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 90) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request();
      logic [2:0]  op;
      logic [63:0] a;
      logic [63:0] b;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 22)      op = OP_MUL;
      else if (pick < 44) op = OP_QUO;
      else if (pick < 66) op = OP_REM;
      else if (pick < 80) op = OP_SHL;
      else if (pick < 94) op = OP_SHR;
      else                op = unused_ops[$urandom_range(0, 2)];
      a = random_word();
      b = random_word();
      if ((op == OP_QUO || op == OP_REM || pick >= 94) && $urandom_range(0, 99) < 6)
         b = '0;
      send_request(op, a, b);
   endtask

   task automatic test_multiply_corners();
      send_request(OP_MUL, WORD_MAX, WORD_MAX);
      send_request(OP_MUL, '0, WORD_MAX);
      send_request(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
      send_request(OP_MUL, WORD_MAX, 64'd2);
   endtask

   task automatic test_divide_corners();
      send_request(OP_QUO, WORD_MAX, 64'd1);
      send_request(OP_QUO, WORD_MAX, '0);
      send_request(OP_QUO, TOP_BIT, 64'd3);
      send_request(OP_QUO, 64'd5, 64'd7);
      send_request(OP_QUO, WORD_MAX, WORD_MAX);
      send_request(OP_REM, WORD_MAX, '0);
      send_request(OP_REM, TOP_BIT | 64'd5, TOP_BIT);
      send_request(OP_REM, WORD_MAX, 64'd10);
      send_request(OP_REM, '0, 64'd1);
   endtask

   task automatic test_shift_corners();
      send_request(OP_SHL, WORD_MAX, '0);
      send_request(OP_SHL, 64'd1, 64'd63);
      send_request(OP_SHL, WORD_MAX, 64'hFFFF_FFFF_FFFF_FFC1);
      send_request(OP_SHR, WORD_MAX, 64'd63);
      send_request(OP_SHR, TOP_BIT, WORD_MAX);
      send_request(OP_SHR, 64'hDEAD_BEEF_0123_4567, 64'd32);
      send_request(OP_SHR, 64'hDEAD_BEEF_0123_4567, 64'd31);
   endtask

   task automatic test_unused_ops();
      send_request(OP_UNUSED_5, WORD_MAX, WORD_MAX);
      send_request(OP_UNUSED_6, WORD_MAX, '0);
      send_request(OP_UNUSED_7, 64'h0123_4567_89AB_CDEF, 64'd9);
   endtask

   task automatic test_random_mix(input int count, input bit idle);
      req_idle_on = idle;
      rsp_idle_on = idle;
      repeat (count) send_random_request();
   endtask

   task automatic test_response_holdoff();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      holdoff_go = 1'b1;
      repeat (20) send_random_request();
   endtask

   task automatic test_sender_pause();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (40) send_random_request();
      wait_for_drain();
      repeat (40) send_random_request();
   endtask

   // response sink: random stall, with a long hold-off on demand
   initial begin : response_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (holdoff_go) begin
            holdoff_go = 1'b0;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (rsp_idle_on) begin
            rsp_stall <= ($urandom_range(0, 99) < 34);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      response_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: result=%h divide_by_zero=%b",
                        rsp_result, rsp_divide_by_zero);
         end else begin
            exp_rsp = pending_responses.pop_front();
            if (rsp_result !== exp_rsp.result ||
                rsp_divide_by_zero !== exp_rsp.divide_by_zero) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch op=%0d a=%h b=%h: expected %h/%b, got %h/%b",
                           exp_rsp.op, exp_rsp.operand_a, exp_rsp.operand_b,
                           exp_rsp.result, exp_rsp.divide_by_zero,
                           rsp_result, rsp_divide_by_zero);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("unsigned_muldiv_shift_unit_64 regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_multiply_corners();
      test_divide_corners();
      test_shift_corners();
      test_unused_ops();
      test_random_mix(300, 1'b0);
      test_random_mix(1300, 1'b1);
      test_response_holdoff();
      test_sender_pause();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("unsigned_muldiv_shift_unit_64 regression: pass");
      else
         $display("unsigned_muldiv_shift_unit_64 regression: fail");
      $finish;
   end

endmodule

>>> sim.f
hdl/umds_pkg.sv
hdl/umds_core.sv
hdl/unsigned_muldiv_shift_unit_64.sv
bench/unsigned_muldiv_shift_unit_64_tb.sv
